// File: hdl/sle_pkg.sv
// Shared constants, codes and control types for the sorted list engine.
package sle_pkg;

  localparam int DEPTH  = 16;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 8;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PCMP_W = (POS_W > IDX_W + 1) ? POS_W : IDX_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT   = 3'd0,
    OP_PUSH_BACK    = 3'd1,
    OP_SORT_INSERT  = 3'd2,
    OP_POP_FRONT    = 3'd3,
    OP_POP_BACK     = 3'd4,
    OP_REMOVE_VALUE = 3'd5,
    OP_REMOVE_POS   = 3'd6,
    OP_NONE         = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2
  } cell_act_t;

  typedef enum logic [2:0] {
    MARK_HEAD  = 3'd0,
    MARK_TAIL  = 3'd1,
    MARK_SORT  = 3'd2,
    MARK_MATCH = 3'd3,
    MARK_POS   = 3'd4
  } mark_t;

  typedef struct packed {
    cell_act_t               act;
    mark_t                   mark;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    logic [CNT_W-1:0]        count;
  } cell_ctl_t;

endpackage

// File: hdl/sle_cell.sv
// One list cell: holds an entry, finds the request's mark and shifts with its neighbours.
module sle_cell import sle_pkg::*; (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [IDX_W-1:0]        idx,
  input  logic signed [VAL_W-1:0] left_entry,
  input  logic signed [VAL_W-1:0] right_entry,
  input  logic                    before_in,
  output logic                    before_out,
  output logic signed [VAL_W-1:0] entry
);

  logic                    in_range;
  logic                    is_tail;
  logic                    pos_hit;
  logic                    mark;
  logic                    at;
  logic signed [VAL_W-1:0] entry_next;

  assign in_range = CNT_W'(idx) < ctl.count;
  assign is_tail  = CNT_W'(idx) == ctl.count;
  assign pos_hit  = (PCMP_W'(idx) + PCMP_W'(1)) == PCMP_W'(ctl.position);

  always_comb begin
    unique case (ctl.mark)
      MARK_HEAD:  mark = (idx == '0);
      MARK_TAIL:  mark = is_tail;
      MARK_SORT:  mark = (in_range && (entry >= ctl.value)) || is_tail;
      MARK_MATCH: mark = in_range && (entry == ctl.value);
      MARK_POS:   mark = in_range && pos_hit;
      default:    mark = 1'b0;
    endcase
  end

  assign at         = mark && !before_in;
  assign before_out = before_in || mark;

  always_comb begin
    unique case (ctl.act)
      ACT_INSERT: begin
        if (before_in) begin
          entry_next = left_entry;
        end else if (at) begin
          entry_next = ctl.value;
        end else begin
          entry_next = entry;
        end
      end
      ACT_DELETE: begin
        entry_next = (before_in || at) ? right_entry : entry;
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: hdl/sorted_list_engine.sv
// Sorted list engine top level: request decode, row of list cells and result register.
// Throughput: one request per cycle unless out_ready holds back a waiting result; the cell
// row applies an accepted request, and the result register is loaded from the updated row
// once the result output is free.
// Reset: synchronous; clears the entry count and the pending and result flags.
// Entries hold no reset value and are only read below the entry count.
module sorted_list_engine import sle_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         operation,
  input  logic signed [VAL_W-1:0] value,
  input  logic [POS_W-1:0]        position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ST_W-1:0]         status,
  output logic [CNT_W-1:0]        count,
  output logic signed [VAL_W-1:0] front_value,
  output logic signed [VAL_W-1:0] back_value
);

  logic [CNT_W-1:0]        list_count;
  logic [CNT_W-1:0]        list_count_next;
  logic                    pend;
  status_t                 pend_status;
  status_t                 st_next;
  logic                    accept;
  logic                    load;
  logic                    full;
  logic                    empty;
  logic                    found;
  cell_ctl_t               ctl;
  cell_act_t               act;
  mark_t                   mark_sel;
  logic [CNT_W-1:0]        last;
  logic [DEPTH:0]          marked;
  logic signed [VAL_W-1:0] cell_entry [DEPTH];

  assign full     = list_count == CNT_W'(DEPTH);
  assign empty    = list_count == '0;
  assign found    = marked[DEPTH];
  assign load     = pend && (!out_valid || out_ready);
  assign in_ready = !pend || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign last     = list_count - CNT_W'(1);

  always_comb begin
    act             = ACT_HOLD;
    mark_sel        = MARK_TAIL;
    st_next         = ST_OK;
    list_count_next = list_count;
    unique case (op_t'(operation))
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORT_INSERT: begin
        unique case (op_t'(operation))
          OP_PUSH_FRONT: mark_sel = MARK_HEAD;
          OP_PUSH_BACK:  mark_sel = MARK_TAIL;
          default:       mark_sel = MARK_SORT;
        endcase
        if (full) begin
          st_next = ST_FULL;
        end else begin
          act             = ACT_INSERT;
          list_count_next = list_count + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        mark_sel = MARK_HEAD;
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          act             = ACT_DELETE;
          list_count_next = list_count - CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          list_count_next = list_count - CNT_W'(1);
        end
      end
      OP_REMOVE_VALUE, OP_REMOVE_POS: begin
        mark_sel = (op_t'(operation) == OP_REMOVE_VALUE) ? MARK_MATCH : MARK_POS;
        if (empty) begin
          st_next = ST_EMPTY;
        end else if (found) begin
          act             = ACT_DELETE;
          list_count_next = list_count - CNT_W'(1);
        end else begin
          st_next = ST_NOTFOUND;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ctl.act      = accept ? act : ACT_HOLD;
    ctl.mark     = mark_sel;
    ctl.value    = value;
    ctl.position = position;
    ctl.count    = list_count;
  end

  assign marked[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sle_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .idx         (IDX_W'(i)),
      .left_entry  ((i == 0) ? value : cell_entry[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == DEPTH - 1) ? cell_entry[i] : cell_entry[(i == DEPTH - 1) ? i : i + 1]),
      .before_in   (marked[i]),
      .before_out  (marked[i+1]),
      .entry       (cell_entry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_count <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        list_count <= list_count_next;
      end
      pend      <= accept || (pend && !load);
      out_valid <= load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= st_next;
    end
    if (load) begin
      status      <= pend_status;
      count       <= list_count;
      front_value <= empty ? '0 : cell_entry[0];
      back_value  <= empty ? '0 : cell_entry[last[IDX_W-1:0]];
    end
  end

endmodule

// File: dv/sorted_list_engine_test.sv
// Testbench for the sorted list engine: directed and random requests checked against a list model.
module sorted_list_engine_test;
  import sle_pkg::*;

  typedef struct {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    int                      gap;
    bit                      settle;
  } list_request_t;

  typedef struct {
    status_t                 status;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] front;
    logic signed [VAL_W-1:0] back;
  } list_outcome_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         operation = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic [POS_W-1:0]        position = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [ST_W-1:0]         status;
  logic [CNT_W-1:0]        count;
  logic signed [VAL_W-1:0] front_value;
  logic signed [VAL_W-1:0] back_value;

  list_request_t pending_requests[$];
  list_outcome_t expected_outcomes[$];

  logic signed [VAL_W-1:0] shadow_list[DEPTH];
  int                      shadow_len = 0;
  logic signed [VAL_W-1:0] value_pool[8];

  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int requests_made = 0;
  int gap_left = 0;
  bit gap_armed = 1'b0;
  int stall_left = 0;
  bit ready_calm = 1'b0;
  int ready_cycles = 0;
  int status_hits[4] = '{0, 0, 0, 0};
  int deepest = 0;

  sorted_list_engine u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .value       (value),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .count       (count),
    .front_value (front_value),
    .back_value  (back_value)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("result %0d: %s", results_seen, msg);
  endtask

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic void drop_entry(input int idx);
    int i;
    for (i = idx; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
    shadow_len--;
  endfunction

  function automatic list_outcome_t predict_outcome(input op_t op,
                                                    input logic signed [VAL_W-1:0] v,
                                                    input logic [POS_W-1:0] p);
    list_outcome_t o;
    int idx;
    int i;
    o.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORT_INSERT: begin
        if (shadow_len >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            idx = 0;
          end else if (op == OP_PUSH_BACK) begin
            idx = shadow_len;
          end else begin
            idx = 0;
            while (idx < shadow_len && shadow_list[idx] < v) idx++;
          end
          for (i = shadow_len; i > idx; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[idx] = v;
          shadow_len++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_len == 0) o.status = ST_EMPTY;
        else drop_entry(0);
      end
      OP_POP_BACK: begin
        if (shadow_len == 0) o.status = ST_EMPTY;
        else shadow_len--;
      end
      OP_REMOVE_VALUE: begin
        if (shadow_len == 0) begin
          o.status = ST_EMPTY;
        end else begin
          idx = 0;
          while (idx < shadow_len && shadow_list[idx] != v) idx++;
          if (idx < shadow_len) drop_entry(idx);
          else o.status = ST_NOTFOUND;
        end
      end
      OP_REMOVE_POS: begin
        if (shadow_len == 0) o.status = ST_EMPTY;
        else if (p == 0 || int'(p) > shadow_len) o.status = ST_NOTFOUND;
        else drop_entry(int'(p) - 1);
      end
      default: ;
    endcase
    o.count = shadow_len[CNT_W-1:0];
    o.front = (shadow_len == 0) ? '0 : shadow_list[0];
    o.back  = (shadow_len == 0) ? '0 : shadow_list[shadow_len - 1];
    return o;
  endfunction

  task automatic queue_request(input op_t op, input logic signed [VAL_W-1:0] v,
                               input logic [POS_W-1:0] p, input int gap, input bit settle);
    list_request_t req;
    req.op       = op;
    req.value    = v;
    req.position = p;
    req.gap      = gap;
    req.settle   = settle;
    pending_requests.push_back(req);
    requests_made++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return value_pool[$urandom_range(0, 7)];
    if (r < 7) return $signed($urandom_range(0, 16)) - 8;
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 9) < 7) return POS_W'($urandom_range(0, DEPTH + 1));
    return POS_W'($urandom_range(0, 255));
  endfunction

  // driver
  always @(posedge clk) begin : request_driver
    list_request_t req;
    logic next_valid;
    int sent_now;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      sent_now = items_sent + ((in_valid && in_ready) ? 1 : 0);
      items_sent <= sent_now;
      if (!in_valid || in_ready) begin
        next_valid = 1'b0;
        if (pending_requests.size() != 0) begin
          if (!gap_armed) begin
            gap_left  = pending_requests[0].gap;
            gap_armed = 1'b1;
          end
          if (gap_left > 0) begin
            gap_left--;
          end else if (!pending_requests[0].settle || results_seen == sent_now) begin
            req        = pending_requests.pop_front();
            gap_armed  = 1'b0;
            next_valid = 1'b1;
            operation <= req.op;
            value     <= req.value;
            position  <= req.position;
          end
        end
        in_valid <= next_valid;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      ready_cycles++;
      if (ready_cycles % 256 == 0) ready_calm = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = ready_calm ? 0 : idle_length();
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // monitor: check results first, then record the request accepted at this edge
  always @(posedge clk) begin : result_monitor
    list_outcome_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_outcomes.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status got %0d, expected %0d", status, want.status));
          if (count !== want.count)
            report_mismatch($sformatf("count got %0d, expected %0d", count, want.count));
          if (front_value !== want.front)
            report_mismatch($sformatf("front got %0d, expected %0d", front_value, want.front));
          if (back_value !== want.back)
            report_mismatch($sformatf("back got %0d, expected %0d", back_value, want.back));
        end
      end
      if (in_valid && in_ready) begin
        want = predict_outcome(op_t'(operation), value, position);
        status_hits[want.status]++;
        if (shadow_len > deepest) deepest = shadow_len;
        expected_outcomes.push_back(want);
      end
    end
  end

  initial begin : stimulus
    int i;
    int j;
    int kind;
    int burst_len;
    int r;
    int waited;
    bit calm;
    bit settle;
    op_t op;

    // empty list behaviour
    queue_request(OP_POP_FRONT, 32'sd5, 8'd1, 0, 1'b0);
    queue_request(OP_POP_BACK, 32'sd5, 8'd1, 0, 1'b0);
    queue_request(OP_REMOVE_VALUE, 32'sd0, 8'd1, 0, 1'b0);
    queue_request(OP_REMOVE_POS, 32'sd0, 8'd1, 0, 1'b0);
    queue_request(OP_NONE, 32'sd0, 8'd0, 0, 1'b0);
    // extremes and ordering
    queue_request(OP_PUSH_FRONT, 32'sh7FFF_FFFF, 8'hFF, 0, 1'b0);
    queue_request(OP_PUSH_BACK, 32'sh8000_0000, 8'h00, 0, 1'b0);
    queue_request(OP_SORT_INSERT, 32'sd0, 8'd0, 1, 1'b0);
    queue_request(OP_SORT_INSERT, 32'sd0, 8'd0, 0, 1'b0);
    queue_request(OP_SORT_INSERT, -32'sd1, 8'd0, 0, 1'b0);
    queue_request(OP_SORT_INSERT, 32'sh7FFF_FFFF, 8'd0, 2, 1'b0);
    queue_request(OP_SORT_INSERT, 32'sh8000_0000, 8'd0, 0, 1'b0);
    queue_request(OP_NONE, 32'sh7FFF_FFFF, 8'hFF, 0, 1'b0);
    // absent value and out-of-range positions, then a value that is present
    queue_request(OP_REMOVE_VALUE, 32'sd12345, 8'd0, 0, 1'b0);
    queue_request(OP_REMOVE_POS, 32'sd0, 8'd0, 0, 1'b0);
    queue_request(OP_REMOVE_POS, 32'sd0, 8'd255, 0, 1'b0);
    queue_request(OP_REMOVE_POS, 32'sd0, 8'd8, 0, 1'b0);
    queue_request(OP_REMOVE_VALUE, 32'sd0, 8'd0, 3, 1'b0);
    // removal by position, then front and back
    queue_request(OP_REMOVE_POS, 32'sd0, 8'd5, 0, 1'b0);
    queue_request(OP_REMOVE_POS, 32'sd0, 8'd2, 0, 1'b0);
    queue_request(OP_POP_FRONT, 32'sd0, 8'd0, 0, 1'b0);
    queue_request(OP_POP_BACK, 32'sd0, 8'd0, 0, 1'b0);
    queue_request(OP_POP_BACK, 32'sd0, 8'd0, 0, 1'b0);
    queue_request(OP_POP_FRONT, 32'sd0, 8'd0, 0, 1'b0);

    // random bursts: fill, drain or mixed
    kind = 0;
    while (requests_made < 1000) begin
      burst_len = (kind == 0) ? $urandom_range(16, 32) : $urandom_range(8, 30);
      calm      = ($urandom_range(0, 4) == 0);
      settle    = (requests_made < 30) || ($urandom_range(0, 9) == 0);
      for (j = 0; j < 8; j++)
        value_pool[j] = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 40) - 20;
      for (i = 0; i < burst_len; i++) begin
        r = $urandom_range(0, 99);
        if (kind == 0) op = (r < 80) ? op_t'($urandom_range(0, 2)) : op_t'($urandom_range(3, 6));
        else if (kind == 1) op = (r < 80) ? op_t'($urandom_range(3, 6)) : op_t'($urandom_range(0, 2));
        else op = op_t'($urandom_range(0, 7));
        queue_request(op, pick_value(), pick_position(), calm ? 0 : idle_length(),
                      settle && i == 0);
      end
      kind = $urandom_range(0, 2);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    waited = 0;
    while (expected_outcomes.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    while (expected_outcomes.size() != 0) begin
      void'(expected_outcomes.pop_front());
      report_mismatch("expected result never arrived");
    end

    $display("%0d requests, %0d results; ok %0d, empty %0d, full %0d, not found %0d",
             items_sent, results_seen, status_hits[ST_OK], status_hits[ST_EMPTY],
             status_hits[ST_FULL], status_hits[ST_NOTFOUND]);
    $display("deepest list reached %0d of %0d entries, %0d mismatches",
             deepest, DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("sorted_list_engine: match");
    end else begin
      $display("sorted_list_engine: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (600000) @(posedge clk);
    $display("timeout waiting for the run to complete");
    $display("sorted_list_engine: mismatch");
    $finish;
  end

endmodule
